@@ hdl/i2p_pkg.sv @@
package i2p_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NUL    = 8'h00;

   localparam logic OP_CHAR = 1'b0;
   localparam logic OP_END  = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] in_char;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
      logic       overflow;
   } rsp_type;

   // datapath to controller
   typedef struct packed {
      logic is_end;
      logic is_space;
      logic is_alnum;
      logic is_lparen;
      logic is_rparen;
      logic stack_empty;
      logic top_is_lparen;
      logic top_prio_ge;
      logic out_free;
   } i2p_status_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic pop;
      logic push;
      logic emit_top;
      logic emit_char;
      logic emit_term;
      logic clear;
   } i2p_cmd_type;

   function automatic logic [1:0] prio(input logic [7:0] c);
      logic [1:0] p;
      if (c == CH_LPAREN) begin
         p = 2'd0;
      end else if (c == CH_PLUS || c == CH_MINUS) begin
         p = 2'd1;
      end else if (c == CH_STAR || c == CH_SLASH) begin
         p = 2'd2;
      end else begin
         p = 2'd3;
      end
      return p;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

@@ hdl/i2p_ctrl.sv @@
module i2p_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   busy,
   input  i2p_pkg::i2p_status_type status,
   output i2p_pkg::i2p_cmd_type    cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   logic state_ff;
   logic state_in;

   assign busy = (state_ff == ST_WORK);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_WORK;
            end
         end
         ST_WORK: begin
            // every step waits for a free output register
            if (status.out_free) begin
               priority if (status.is_end) begin
                  if (!status.stack_empty) begin
                     cmd.pop      = 1'b1;
                     cmd.emit_top = 1'b1;
                  end else begin
                     cmd.emit_term = 1'b1;
                     cmd.clear     = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else if (status.is_space) begin
                  state_in = ST_IDLE;
               end else if (status.is_alnum) begin
                  cmd.emit_char = 1'b1;
                  state_in      = ST_IDLE;
               end else if (status.is_lparen) begin
                  cmd.push = 1'b1;
                  state_in = ST_IDLE;
               end else if (status.is_rparen) begin
                  if (!status.stack_empty) begin
                     cmd.pop = 1'b1;
                     if (status.top_is_lparen) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.emit_top = 1'b1;
                     end
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  if (!status.stack_empty && status.top_prio_ge) begin
                     cmd.pop      = 1'b1;
                     cmd.emit_top = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/i2p_dp.sv @@
module i2p_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  i2p_pkg::req_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output i2p_pkg::rsp_type        rsp_data,
   input  i2p_pkg::i2p_cmd_type    cmd,
   output i2p_pkg::i2p_status_type status
);

   logic                      op_ff;
   logic [7:0]                char_ff;
   logic [7:0]                stack_ff [i2p_pkg::STACK_DEPTH];
   logic [i2p_pkg::CNT_W-1:0] count_ff;
   logic [i2p_pkg::CNT_W-1:0] count_in;
   logic                      overflow_ff;
   logic                      overflow_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   i2p_pkg::rsp_type          rsp_data_ff;
   i2p_pkg::rsp_type          rsp_data_in;
   logic [i2p_pkg::IDX_W-1:0] below_idx;
   logic [7:0]                top_ff;
   logic                      stack_full;
   logic                      emit;

   assign below_idx  = count_ff[i2p_pkg::IDX_W-1:0] - i2p_pkg::IDX_W'(2);
   assign stack_full = (count_ff == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));

   assign status.is_end        = (op_ff == i2p_pkg::OP_END);
   assign status.is_space      = (char_ff == i2p_pkg::CH_SPACE);
   assign status.is_alnum      = i2p_pkg::is_alnum(char_ff);
   assign status.is_lparen     = (char_ff == i2p_pkg::CH_LPAREN);
   assign status.is_rparen     = (char_ff == i2p_pkg::CH_RPAREN);
   assign status.stack_empty   = (count_ff == '0);
   assign status.top_is_lparen = (top_ff == i2p_pkg::CH_LPAREN);
   assign status.top_prio_ge   = (i2p_pkg::prio(top_ff) >= i2p_pkg::prio(char_ff));
   assign status.out_free      = !rsp_valid_ff || !rsp_stall;

   assign emit = cmd.emit_top || cmd.emit_char || cmd.emit_term;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (cmd.clear) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (cmd.pop) begin
         count_in = count_ff - i2p_pkg::CNT_W'(1);
      end else if (cmd.push) begin
         // a push onto a full stack is dropped
         if (stack_full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + i2p_pkg::CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.emit_term) begin
         rsp_data_in.out_char = i2p_pkg::CH_NUL;
         rsp_data_in.last     = 1'b1;
         rsp_data_in.overflow = overflow_ff;
      end else if (cmd.emit_top) begin
         rsp_data_in.out_char = top_ff;
         rsp_data_in.last     = 1'b0;
         rsp_data_in.overflow = 1'b0;
      end else if (cmd.emit_char) begin
         rsp_data_in.out_char = char_ff;
         rsp_data_in.last     = 1'b0;
         rsp_data_in.overflow = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.load_item) begin
         op_ff   <= req_data.op;
         char_ff <= req_data.in_char;
      end
      if (cmd.push && !stack_full) begin
         stack_ff[count_ff[i2p_pkg::IDX_W-1:0]] <= char_ff;
         top_ff                                 <= char_ff;
      end else if (cmd.pop) begin
         // the entry below the top becomes the new top
         top_ff <= stack_ff[below_idx];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hdl/infix_to_postfix_converter_core.sv @@
// Infix to postfix conversion with a 16-entry operator stack. One character
// or end marker is taken per transfer; the block then works one step per
// cycle while the output is not stalled: it takes the item, then does one
// step per stack pop or output, and takes no new item until it is done.
// A step waits while the output register holds a result that is stalled.
// Pushes onto a full stack are dropped and reported on the terminator of
// that expression.
module infix_to_postfix_converter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  i2p_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output i2p_pkg::rsp_type rsp_data
);

   i2p_pkg::i2p_status_type status;
   i2p_pkg::i2p_cmd_type    cmd;
   logic                    busy;

   assign req_stall = busy;

   i2p_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd)
   );

   i2p_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

@@ hdl/i2p_checker.sv @@
module i2p_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input i2p_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input i2p_pkg::rsp_type rsp_data
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a stalled request stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   // only the terminator carries the overflow flag
   a_ovf_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.last)
      else $error("overflow set on a non-terminator result");

   a_term_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.out_char == i2p_pkg::CH_NUL)
      else $error("terminator with non-zero character");

   // one item in work at a time
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while an item is in work");

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
